@@ sv/sqtpm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the test pairing table of the point matcher.
// Used by every module of the block; depends on nothing.
package sqtpm_pkg;

  localparam int DEF_MAX_POINTS = 16;
  localparam int DEF_MAX_HITS   = 63;

  localparam int COORD_W    = 11;
  localparam int IDX_W      = 6;
  localparam int DIST_W     = 23;
  localparam int TOL_W      = 12;
  localparam int SIDE_W     = 11;
  localparam int TRI_TOT_W  = 16;
  localparam int SQ_TOT_W   = 20;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;
  localparam int SLOT_CNT   = 8;

  localparam logic [TOL_W-1:0]  TOL_RST    = 12'd48;
  localparam logic [SIDE_W-1:0] TRI_LO_RST = 11'd15;
  localparam logic [SIDE_W-1:0] TRI_HI_RST = 11'd27;
  localparam logic [SIDE_W-1:0] SQ_LO_RST  = 11'd25;
  localparam logic [SIDE_W-1:0] SQ_HI_RST  = 11'd35;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOL    = 3'd0,
    REG_TRI_LO = 3'd1,
    REG_TRI_HI = 3'd2,
    REG_SQ_LO  = 3'd3,
    REG_SQ_HI  = 3'd4
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRI  = 2'd0,
    KIND_SQ   = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S12 = 3'd0,
    S13 = 3'd1,
    S14 = 3'd2,
    S23 = 3'd3,
    S24 = 3'd4,
    S34 = 3'd5
  } slot_e;

  typedef enum logic [1:0] {
    T_TRI = 2'd0,
    T_D2  = 2'd1,
    T_D3  = 2'd2,
    T_D4  = 2'd3
  } test_e;

  typedef struct packed {
    slot_e a;
    slot_e b;
  } pair_t;

  typedef struct packed {
    logic             dist_go;
    slot_e            dist_slot;
    logic [IDX_W-1:0] dist_pa;
    logic [IDX_W-1:0] dist_pb;
    logic             near_go;
    slot_e            near_a;
    slot_e            near_b;
    logic             acc_init;
    logic             acc_sq;
    logic             batch_clear;
    logic             tri_inc;
    logic             sq_inc;
    logic             cap_set;
    logic             emit_hit;
    logic             emit_sq;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic [IDX_W-1:0] id;
    logic             emit_done;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W:0] held;
    logic           hit;
    logic           room;
    logic           out_free;
    test_e          diag;
  } sts_t;

  // Distance pairs compared at each step of a triangle or square test.
  function automatic pair_t near_pair(input test_e tk, input logic [2:0] step);
    pair_t p;
    p = '{a: S12, b: S23};
    case (tk)
      T_TRI: begin
        case (step)
          3'd0: p = '{a: S12, b: S23};
          3'd1: p = '{a: S23, b: S13};
          default: p = '{a: S13, b: S12};
        endcase
      end
      T_D2: begin
        case (step)
          3'd0: p = '{a: S12, b: S34};
          3'd1: p = '{a: S13, b: S23};
          3'd2: p = '{a: S23, b: S24};
          3'd3: p = '{a: S24, b: S14};
          default: p = '{a: S14, b: S13};
        endcase
      end
      T_D3: begin
        case (step)
          3'd0: p = '{a: S13, b: S24};
          3'd1: p = '{a: S12, b: S23};
          3'd2: p = '{a: S23, b: S34};
          3'd3: p = '{a: S34, b: S14};
          default: p = '{a: S14, b: S12};
        endcase
      end
      default: begin
        case (step)
          3'd0: p = '{a: S14, b: S23};
          3'd1: p = '{a: S12, b: S24};
          3'd2: p = '{a: S24, b: S34};
          3'd3: p = '{a: S34, b: S13};
          default: p = '{a: S13, b: S12};
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

@@ sv/sqtpm_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// Depends on sqtpm_pkg for its defaults; used for the point store and the distance slots.
module sqtpm_ram #(
  parameter int WIDTH = sqtpm_pkg::DIST_W,
  parameter int DEPTH = sqtpm_pkg::SLOT_CNT
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                       rdata_a_o,
  output logic [WIDTH-1:0]                       rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ sv/sqtpm_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the point matcher: walks triples and quadruples and issues
// distance, compare and emit commands. Depends on sqtpm_pkg.
module sqtpm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sqtpm_pkg::sts_t  sts_i,
  output logic             in_ready_o,
  output sqtpm_pkg::cmd_t  cmd_o
);

  localparam int CW = sqtpm_pkg::IDX_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_TRI_D, ST_TRI_T, ST_TRI_R,
    ST_SQ_D, ST_SQ_T, ST_SQ_R, ST_NEXT, ST_DONE
  } state_e;

  state_e        state_q;
  logic [3:0]    step_q;
  logic [CW-1:0] i_q, j_q, k_q, l_q;
  logic          hit_go;
  sqtpm_pkg::pair_t pr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign hit_go = !sts_i.hit || !sts_i.room || sts_i.out_free;

  always_comb begin
    cmd_o = '0;
    pr    = sqtpm_pkg::near_pair(sqtpm_pkg::T_TRI, step_q[2:0]);
    unique case (state_q)
      ST_START: cmd_o.batch_clear = 1'b1;
      ST_TRI_D: begin
        cmd_o.dist_go = (step_q < 4'd3);
        unique case (step_q[1:0])
          2'd0: begin
            cmd_o.dist_slot = sqtpm_pkg::S12;
            cmd_o.dist_pa = i_q[CW-2:0];
            cmd_o.dist_pb = j_q[CW-2:0];
          end
          2'd1: begin
            cmd_o.dist_slot = sqtpm_pkg::S13;
            cmd_o.dist_pa = i_q[CW-2:0];
            cmd_o.dist_pb = k_q[CW-2:0];
          end
          default: begin
            cmd_o.dist_slot = sqtpm_pkg::S23;
            cmd_o.dist_pa = j_q[CW-2:0];
            cmd_o.dist_pb = k_q[CW-2:0];
          end
        endcase
      end
      ST_SQ_D: begin
        cmd_o.dist_go = (step_q < 4'd3);
        cmd_o.dist_pb = l_q[CW-2:0];
        unique case (step_q[1:0])
          2'd0: begin
            cmd_o.dist_slot = sqtpm_pkg::S14;
            cmd_o.dist_pa = i_q[CW-2:0];
          end
          2'd1: begin
            cmd_o.dist_slot = sqtpm_pkg::S24;
            cmd_o.dist_pa = j_q[CW-2:0];
          end
          default: begin
            cmd_o.dist_slot = sqtpm_pkg::S34;
            cmd_o.dist_pa = k_q[CW-2:0];
          end
        endcase
      end
      ST_TRI_T: begin
        cmd_o.acc_init = (step_q == 4'd0);
        cmd_o.near_go  = (step_q < 4'd3);
        cmd_o.near_a   = pr.a;
        cmd_o.near_b   = pr.b;
      end
      ST_SQ_T: begin
        pr = sqtpm_pkg::near_pair(sts_i.diag, step_q[2:0]);
        cmd_o.acc_init = (step_q == 4'd0);
        cmd_o.acc_sq   = 1'b1;
        cmd_o.near_go  = (step_q < 4'd5);
        cmd_o.near_a   = pr.a;
        cmd_o.near_b   = pr.b;
      end
      ST_TRI_R, ST_SQ_R: begin
        cmd_o.tri_inc  = (state_q == ST_TRI_R) && sts_i.hit && hit_go;
        cmd_o.sq_inc   = (state_q == ST_SQ_R) && sts_i.hit && hit_go;
        cmd_o.cap_set  = sts_i.hit && !sts_i.room;
        cmd_o.emit_hit = sts_i.hit && sts_i.room && sts_i.out_free;
        cmd_o.emit_sq  = (state_q == ST_SQ_R);
        cmd_o.ia = i_q[CW-2:0];
        cmd_o.ib = j_q[CW-2:0];
        cmd_o.ic = k_q[CW-2:0];
        cmd_o.id = (state_q == ST_SQ_R) ? l_q[CW-2:0] : '0;
      end
      ST_DONE: cmd_o.emit_done = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      l_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_START;
        end
        ST_START: begin
          step_q <= '0;
          if (sts_i.held < CW'(3)) begin
            state_q <= ST_DONE;
          end else begin
            i_q <= CW'(0);
            j_q <= CW'(1);
            k_q <= CW'(2);
            state_q <= ST_TRI_D;
          end
        end
        ST_TRI_D, ST_SQ_D: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd5) begin
            step_q  <= '0;
            state_q <= (state_q == ST_TRI_D) ? ST_TRI_T : ST_SQ_T;
          end
        end
        ST_TRI_T: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd6) begin
            step_q  <= '0;
            state_q <= ST_TRI_R;
          end
        end
        ST_SQ_T: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd8) begin
            step_q  <= '0;
            state_q <= ST_SQ_R;
          end
        end
        ST_TRI_R: begin
          if (hit_go) begin
            if (k_q + CW'(1) < sts_i.held) begin
              l_q <= k_q + CW'(1);
              state_q <= ST_SQ_D;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end
        ST_SQ_R: begin
          if (hit_go) begin
            if (l_q + CW'(1) < sts_i.held) begin
              l_q <= l_q + CW'(1);
              state_q <= ST_SQ_D;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end
        ST_NEXT: begin
          if (k_q + CW'(1) < sts_i.held) begin
            k_q <= k_q + CW'(1);
            state_q <= ST_TRI_D;
          end else if (j_q + CW'(2) < sts_i.held) begin
            j_q <= j_q + CW'(1);
            k_q <= j_q + CW'(2);
            state_q <= ST_TRI_D;
          end else if (i_q + CW'(3) < sts_i.held) begin
            i_q <= i_q + CW'(1);
            j_q <= i_q + CW'(2);
            k_q <= i_q + CW'(3);
            state_q <= ST_TRI_D;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRI_D) |-> (i_q < j_q && j_q < k_q && k_q < sts_i.held))
    else $error("triple indices out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ_D) |-> (k_q < l_q && l_q < sts_i.held))
    else $error("fourth index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sts_i.out_free) |=> (state_q == ST_IDLE))
    else $error("done beat did not return to idle");

endmodule

@@ sv/sqtpm_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the point matcher: point store, distance unit, tolerance
// compare unit, counters and output register. Depends on sqtpm_pkg, sqtpm_ram.
module sqtpm_dp #(
  parameter int MAX_POINTS = sqtpm_pkg::DEF_MAX_POINTS,
  parameter int MAX_HITS   = sqtpm_pkg::DEF_MAX_HITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [sqtpm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sqtpm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic [sqtpm_pkg::COORD_W-1:0]        in_x_i,
  input  logic [sqtpm_pkg::COORD_W-1:0]        in_y_i,
  input  sqtpm_pkg::cmd_t                      cmd_i,
  output sqtpm_pkg::sts_t                      sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sqtpm_pkg::KIND_W-1:0]         out_kind_o,
  output logic [sqtpm_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                 out_last_o
);

  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int HW  = $clog2(MAX_HITS + 1);
  localparam int CRW = sqtpm_pkg::COORD_W;
  localparam int DW  = sqtpm_pkg::DIST_W;
  localparam int SW  = sqtpm_pkg::SIDE_W;
  localparam int TW  = sqtpm_pkg::TOL_W;
  localparam int LW  = DW + 8;
  localparam int T2W = 2 * TW;
  localparam int DDW = 2 * LW;
  localparam int TBW = T2W + DW;

  // Configuration registers and their squares.
  logic [TW-1:0]    tol_q;
  logic [SW-1:0]    tri_lo_q, tri_hi_q, sq_lo_q, sq_hi_q;
  logic [T2W-1:0]   t2_q;
  logic [2*SW-1:0]  tri_lo2_q, tri_hi2_q, sq_lo2_q, sq_hi2_q;

  logic [NW-1:0]    held_q;
  logic             dropped_q;
  logic             store_we;

  logic [2*CRW-1:0] pa_data, pb_data;
  logic             dv1_q, dv2_q;
  logic [2:0]       dslot1_q, dslot2_q;
  logic [CRW-1:0]   dx, dy;
  logic [2*CRW-1:0] sqx_q, sqy_q;
  logic [DW-1:0]    dsum;
  logic [DW-1:0]    d12_q, d13_q, d14_q;

  logic [DW-1:0]    na, nb, nbig, nsmall;
  logic [LW-1:0]    lhs;
  logic             nv0_q, nv1_q, nv2_q;
  logic             nsm1_q, nsm2_q;
  logic [LW-1:0]    nd_q;
  logic [DW-1:0]    nb_q;
  logic [DDW-1:0]   ndd_q;
  logic [TBW-1:0]   ntb_q;
  logic             near_ok;

  logic             acc_q;
  logic [DW-1:0]    bsel;
  logic [2*SW-1:0]  blo2, bhi2;
  logic             inb;
  sqtpm_pkg::test_e diag;

  logic [sqtpm_pkg::TRI_TOT_W-1:0] tri_tot_q;
  logic [sqtpm_pkg::SQ_TOT_W-1:0]  sq_tot_q;
  logic [HW-1:0]                   emit_cnt_q;
  logic                            cap_q;
  logic                            out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= sqtpm_pkg::TOL_RST;
      tri_lo_q <= sqtpm_pkg::TRI_LO_RST;
      tri_hi_q <= sqtpm_pkg::TRI_HI_RST;
      sq_lo_q  <= sqtpm_pkg::SQ_LO_RST;
      sq_hi_q  <= sqtpm_pkg::SQ_HI_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sqtpm_pkg::REG_TOL:    tol_q    <= cfg_data_i;
        sqtpm_pkg::REG_TRI_LO: tri_lo_q <= cfg_data_i[SW-1:0];
        sqtpm_pkg::REG_TRI_HI: tri_hi_q <= cfg_data_i[SW-1:0];
        sqtpm_pkg::REG_SQ_LO:  sq_lo_q  <= cfg_data_i[SW-1:0];
        sqtpm_pkg::REG_SQ_HI:  sq_hi_q  <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    t2_q      <= T2W'(tol_q) * T2W'(tol_q);
    tri_lo2_q <= (2*SW)'(tri_lo_q) * (2*SW)'(tri_lo_q);
    tri_hi2_q <= (2*SW)'(tri_hi_q) * (2*SW)'(tri_hi_q);
    sq_lo2_q  <= (2*SW)'(sq_lo_q) * (2*SW)'(sq_lo_q);
    sq_hi2_q  <= (2*SW)'(sq_hi_q) * (2*SW)'(sq_hi_q);
  end

  // Point store.
  assign store_we = in_valid_i && (held_q < NW'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.emit_done) begin
      held_q    <= '0;
      dropped_q <= 1'b0;
    end else if (in_valid_i) begin
      if (store_we) held_q <= held_q + NW'(1);
      else dropped_q <= 1'b1;
    end
  end

  sqtpm_ram #(.WIDTH(2 * CRW), .DEPTH(MAX_POINTS)) u_points (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .waddr_i   (held_q[IW-1:0]),
    .wdata_i   ({in_y_i, in_x_i}),
    .raddr_a_i (cmd_i.dist_pa[IW-1:0]),
    .raddr_b_i (cmd_i.dist_pb[IW-1:0]),
    .rdata_a_o (pa_data),
    .rdata_b_o (pb_data)
  );

  // Squared distance pipeline.
  assign dx = (pa_data[CRW-1:0] > pb_data[CRW-1:0]) ? pa_data[CRW-1:0] - pb_data[CRW-1:0]
                                                    : pb_data[CRW-1:0] - pa_data[CRW-1:0];
  assign dy = (pa_data[2*CRW-1:CRW] > pb_data[2*CRW-1:CRW])
            ? pa_data[2*CRW-1:CRW] - pb_data[2*CRW-1:CRW]
            : pb_data[2*CRW-1:CRW] - pa_data[2*CRW-1:CRW];
  assign dsum = DW'(sqx_q) + DW'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv1_q <= 1'b0;
      dv2_q <= 1'b0;
    end else begin
      dv1_q <= cmd_i.dist_go;
      dv2_q <= dv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dslot1_q <= cmd_i.dist_slot;
    dslot2_q <= dslot1_q;
    sqx_q    <= (2*CRW)'(dx) * (2*CRW)'(dx);
    sqy_q    <= (2*CRW)'(dy) * (2*CRW)'(dy);
    if (dv2_q) begin
      unique case (dslot2_q)
        sqtpm_pkg::S12: d12_q <= dsum;
        sqtpm_pkg::S13: d13_q <= dsum;
        sqtpm_pkg::S14: d14_q <= dsum;
        default: ;
      endcase
    end
  end

  sqtpm_ram #(.WIDTH(DW), .DEPTH(sqtpm_pkg::SLOT_CNT)) u_slots (
    .clk_i     (clk_i),
    .we_i      (dv2_q),
    .waddr_i   (dslot2_q),
    .wdata_i   (dsum),
    .raddr_a_i (cmd_i.near_a),
    .raddr_b_i (cmd_i.near_b),
    .rdata_a_o (na),
    .rdata_b_o (nb)
  );

  // Tolerance compare: |sqrt(a) - sqrt(b)| <= T/16 on squared values.
  assign nbig   = (na < nb) ? nb : na;
  assign nsmall = (na < nb) ? na : nb;
  assign lhs    = {nbig - nsmall, 8'd0};
  assign near_ok = nsm2_q || (ndd_q <= DDW'({ntb_q, 10'd0}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv0_q <= 1'b0;
      nv1_q <= 1'b0;
      nv2_q <= 1'b0;
    end else begin
      nv0_q <= cmd_i.near_go;
      nv1_q <= nv0_q;
      nv2_q <= nv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nsm1_q <= (lhs <= LW'(t2_q));
    nd_q   <= lhs - LW'(t2_q);
    nb_q   <= nsmall;
    nsm2_q <= nsm1_q;
    ndd_q  <= DDW'(nd_q) * DDW'(nd_q);
    ntb_q  <= TBW'(t2_q) * TBW'(nb_q);
  end

  // Side bounds and diagonal choice.
  always_comb begin
    if (d12_q < d13_q) diag = (d13_q < d14_q) ? sqtpm_pkg::T_D4 : sqtpm_pkg::T_D3;
    else diag = (d12_q < d14_q) ? sqtpm_pkg::T_D4 : sqtpm_pkg::T_D2;
  end

  assign bsel = (cmd_i.acc_sq && diag == sqtpm_pkg::T_D3) ? d12_q : d13_q;
  assign blo2 = cmd_i.acc_sq ? sq_lo2_q : tri_lo2_q;
  assign bhi2 = cmd_i.acc_sq ? sq_hi2_q : tri_hi2_q;
  assign inb  = (bsel > DW'(blo2)) && (bsel < DW'(bhi2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else if (cmd_i.acc_init) begin
      acc_q <= inb;
    end else if (nv2_q) begin
      acc_q <= acc_q && near_ok;
    end
  end

  // Counters and output register.
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_tot_q  <= '0;
      sq_tot_q   <= '0;
      emit_cnt_q <= '0;
      cap_q      <= 1'b0;
    end else if (cmd_i.batch_clear) begin
      tri_tot_q  <= '0;
      sq_tot_q   <= '0;
      emit_cnt_q <= '0;
      cap_q      <= 1'b0;
    end else begin
      if (cmd_i.tri_inc) tri_tot_q <= tri_tot_q + sqtpm_pkg::TRI_TOT_W'(1);
      if (cmd_i.sq_inc) sq_tot_q <= sq_tot_q + sqtpm_pkg::SQ_TOT_W'(1);
      if (cmd_i.emit_hit) emit_cnt_q <= emit_cnt_q + HW'(1);
      if (cmd_i.cap_set) cap_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_hit || cmd_i.emit_done) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hit) begin
      out_kind_o <= cmd_i.emit_sq ? sqtpm_pkg::KIND_SQ : sqtpm_pkg::KIND_TRI;
      out_data_o <= sqtpm_pkg::OUT_DATA_W'({cmd_i.id, cmd_i.ic, cmd_i.ib, cmd_i.ia});
      out_last_o <= 1'b0;
    end else if (cmd_i.emit_done) begin
      out_kind_o <= sqtpm_pkg::KIND_DONE;
      out_data_o <= sqtpm_pkg::OUT_DATA_W'({cap_q || dropped_q, sq_tot_q, tri_tot_q,
                                            24'd0});
      out_last_o <= 1'b1;
    end
  end

  assign sts_o.held     = (sqtpm_pkg::IDX_W + 1)'(held_q);
  assign sts_o.hit      = acc_q;
  assign sts_o.room     = (emit_cnt_q < HW'(MAX_HITS));
  assign sts_o.out_free = out_free;
  assign sts_o.diag     = diag;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= NW'(MAX_POINTS))
    else $error("point count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= HW'(MAX_HITS))
    else $error("hit beats beyond cap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.near_go |-> (!dv1_q && !dv2_q && !cmd_i.dist_go))
    else $error("compare issued while distances still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_hit || cmd_i.emit_done) |-> out_free)
    else $error("beat loaded into a full output register");

endmodule

@@ sv/square_triangle_point_matcher_top.sv @@
`timescale 1ns / 1ps
// Top level of the square and triangle point matcher.
// Depends on sqtpm_pkg, sqtpm_ram, sqtpm_ctrl and sqtpm_dp.
//
// Points arrive as beats on the s_axis channel; tlast marks the final point
// of a batch. Up to MAX_POINTS points are held; later ones are dropped and
// flagged. On the final point the block walks every triple and quadruple
// and sends hit beats on m_axis, then one done beat with tlast high that
// carries the totals and the overflow flag, after which the batch is empty.
// s_axis_tready is high only while the block is idle, so points are taken
// back to back until the final one and the search runs between batches.
// Triple and quadruple tests share the single distance unit and tolerance
// compare pipeline. A stalled m_axis holds the search at its next hit until
// the beat is taken. Configuration writes on the cfg channel are always
// accepted; the user must make them while the block is idle, which the
// block itself does not enforce. Reset empties the batch, loads the default
// registers and drops any pending output beat.
module square_triangle_point_matcher_top #(
  parameter int MAX_POINTS = sqtpm_pkg::DEF_MAX_POINTS,
  parameter int MAX_HITS   = sqtpm_pkg::DEF_MAX_HITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sqtpm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sqtpm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x, point_y, zero fill.
  input  logic [sqtpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // index_a, index_b, index_c, index_d, triangle_total, square_total,
  // overflow_flag, zero fill.
  output logic [sqtpm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // match_kind.
  output logic [sqtpm_pkg::KIND_W-1:0]        m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int CRW = sqtpm_pkg::COORD_W;

  logic            in_beat;
  sqtpm_pkg::cmd_t cmd;
  sqtpm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;
  assign in_beat     = s_axis_tvalid && s_axis_tready;

  sqtpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_beat && s_axis_tlast),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  sqtpm_dp #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_HITS   (MAX_HITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_beat),
    .in_x_i      (s_axis_tdata[CRW-1:0]),
    .in_y_i      (s_axis_tdata[2*CRW-1:CRW]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
